### hw/rtl/zoomed_blit_address_generator_macros.svh
// assertion macros shared by the blit address generator modules
`ifndef ZOOMED_BLIT_ADDRESS_GENERATOR_MACROS_SVH
`define ZOOMED_BLIT_ADDRESS_GENERATOR_MACROS_SVH

// implication checked on every rising clock edge, off while reset is low
`define ZBAG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check with no reset term, for properties that hold during reset too
`define ZBAG_ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/zbag_pkg.sv
package zbag_pkg;

  // field widths
  localparam int ZoomW  = 8;
  localparam int StartW = 10;
  localparam int DimW   = 11;
  localparam int CntW   = 11;
  localparam int ColW   = 18;
  localparam int RowW   = 13;
  localparam int RepW   = 7;
  localparam int AddrW  = 20;
  localparam int CfgIdxW = 3;

  // zoom saturation limit
  localparam int ZoomLimit = 64;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgZoom     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgStartCol = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgStartRow = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgWidth    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgHeight   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgBottomUp = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgSpanCols = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpanRows = 3'd7;

  // live configuration
  typedef struct packed {
    logic signed [ZoomW-1:0] zoom;
    logic [StartW-1:0]       start_col;
    logic [StartW-1:0]       start_row;
    logic [DimW-1:0]         image_width;
    logic [DimW-1:0]         image_height;
    logic                    bottom_up;
    logic [DimW-1:0]         span_cols;
    logic [DimW-1:0]         span_rows;
  } cfg_t;

  // one pixel handed from the walker to the address stage
  typedef struct packed {
    logic [RowW-1:0] src_row;
    logic [ColW-1:0] src_col;
    logic [DimW-1:0] width;
    logic [CntW-1:0] screen_col;
    logic [CntW-1:0] screen_row;
    logic            out_of_range;
    logic            last;
  } pix_t;

endpackage

### hw/rtl/zbag_cfg.sv
module zbag_cfg
  import zbag_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [DimW-1:0]     cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // register file, written by index on each configuration transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zoom         <= 8'sd1;
      cfg_q.start_col    <= '0;
      cfg_q.start_row    <= '0;
      cfg_q.image_width  <= 11'd1024;
      cfg_q.image_height <= 11'd1024;
      cfg_q.bottom_up    <= 1'b0;
      cfg_q.span_cols    <= '0;
      cfg_q.span_rows    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgZoom:     cfg_q.zoom         <= cfg_data_i[ZoomW-1:0];
        CfgStartCol: cfg_q.start_col    <= cfg_data_i[StartW-1:0];
        CfgStartRow: cfg_q.start_row    <= cfg_data_i[StartW-1:0];
        CfgWidth:    cfg_q.image_width  <= cfg_data_i;
        CfgHeight:   cfg_q.image_height <= cfg_data_i;
        CfgBottomUp: cfg_q.bottom_up    <= cfg_data_i[0];
        CfgSpanCols: cfg_q.span_cols    <= cfg_data_i;
        CfgSpanRows: cfg_q.span_rows    <= cfg_data_i;
        default:     cfg_q.zoom         <= cfg_q.zoom;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/zbag_walk.sv
`include "zoomed_blit_address_generator_macros.svh"

module zbag_walk
  import zbag_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_SPAN   = 2048
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic restart_i,
  input  logic down_ready_i,
  output logic pix_valid_o,
  output pix_t pix_o
);

  localparam logic [12:0] MaxW  = 13'(MAX_WIDTH);
  localparam logic [12:0] MaxH  = 13'(MAX_HEIGHT);
  localparam logic [12:0] MaxS1 = 13'(MAX_SPAN - 1);

  // walk state
  logic [CntW-1:0] col_cnt_q, col_cnt_d;
  logic [CntW-1:0] row_cnt_q, row_cnt_d;
  logic [ColW-1:0] src_col_q, src_col_d;
  logic [RowW-1:0] src_row_q, src_row_d;
  logic [RepW-1:0] rep_x_q, rep_x_d;
  logic [RepW-1:0] rep_y_q, rep_y_d;
  logic            active_q, active_d;
  logic            pix_valid_q, pix_valid_d;
  pix_t            pix_q;

  logic signed [ZoomW-1:0] zoom_eff;
  logic            zoom_pos;
  logic [RepW-1:0] mag, rep;
  logic [DimW-1:0] w_eff, h_eff, span_c, span_r;
  logic [RowW-1:0] begin_row;
  logic [CntW-1:0] cur_col_cnt, cur_row_cnt;
  logic [ColW-1:0] cur_src_col;
  logic [RowW-1:0] cur_src_row;
  logic [RepW-1:0] cur_rep_x, cur_rep_y;
  logic            emit, accept, cur_oor, cur_last, row_end;
  logic signed [RowW:0] row_sum, row_hi, row_min;
  logic [RowW-1:0] row_step;

  // effective register values after saturation
  always_comb begin
    if (cfg_i.zoom == 8'sd0) begin
      zoom_eff = 8'sd1;
    end else if (cfg_i.zoom > 8'(ZoomLimit)) begin
      zoom_eff = 8'(ZoomLimit);
    end else if (cfg_i.zoom < -8'(ZoomLimit)) begin
      zoom_eff = -8'(ZoomLimit);
    end else begin
      zoom_eff = cfg_i.zoom;
    end
  end

  assign zoom_pos = !zoom_eff[ZoomW-1];
  assign mag      = zoom_pos ? zoom_eff[RepW-1:0] : RepW'(-zoom_eff);
  assign rep      = zoom_pos ? mag : RepW'(1);

  assign w_eff  = ({2'b00, cfg_i.image_width} > MaxW) ? MaxW[DimW-1:0] : cfg_i.image_width;
  assign h_eff  = ({2'b00, cfg_i.image_height} > MaxH) ? MaxH[DimW-1:0] : cfg_i.image_height;
  assign span_c = ({2'b00, cfg_i.span_cols} > MaxS1) ? MaxS1[DimW-1:0] : cfg_i.span_cols;
  assign span_r = ({2'b00, cfg_i.span_rows} > MaxS1) ? MaxS1[DimW-1:0] : cfg_i.span_rows;

  // first row of a pass, mirrored for bottom-up images
  assign begin_row = cfg_i.bottom_up
                   ? {2'b00, h_eff} - RowW'(1) - {3'b000, cfg_i.start_row}
                   : {3'b000, cfg_i.start_row};

  // pixel position in use: a fresh pass or the stored walk
  assign cur_col_cnt = restart_i ? '0 : col_cnt_q;
  assign cur_row_cnt = restart_i ? '0 : row_cnt_q;
  assign cur_src_col = restart_i ? {8'd0, cfg_i.start_col} : src_col_q;
  assign cur_src_row = restart_i ? begin_row : src_row_q;
  assign cur_rep_x   = restart_i ? rep : rep_x_q;
  assign cur_rep_y   = restart_i ? rep : rep_y_q;

  assign emit    = restart_i || active_q;
  assign in_ready_o = !pix_valid_q || down_ready_i;
  assign accept  = in_valid_i && in_ready_o;

  // range flag and end of rectangle
  assign cur_oor  = (cur_src_col >= {7'd0, w_eff}) || cur_src_row[RowW-1]
                 || ($signed(cur_src_row) >= $signed({2'b00, h_eff}));
  assign row_end  = cur_col_cnt >= span_c;
  assign cur_last = row_end && (cur_row_cnt >= span_r);

  // row steps: decimation step clamped to the image, single-row step for magnification
  always_comb begin
    row_sum = $signed({cur_src_row[RowW-1], cur_src_row})
            + (cfg_i.bottom_up ? -$signed({7'd0, mag}) : $signed({7'd0, mag}));
    row_hi  = $signed({3'b000, h_eff}) - 14'sd1;
    row_min = (row_sum > row_hi) ? row_hi : row_sum;
    if (row_min < 14'sd0) begin
      row_min = 14'sd0;
    end
    row_step = cfg_i.bottom_up ? cur_src_row - RowW'(1) : cur_src_row + RowW'(1);
  end

  // next walk state
  always_comb begin
    col_cnt_d = cur_col_cnt;
    row_cnt_d = cur_row_cnt;
    src_col_d = cur_src_col;
    src_row_d = cur_src_row;
    rep_x_d   = cur_rep_x;
    rep_y_d   = cur_rep_y;
    active_d  = !cur_last;
    if (!cur_last) begin
      if (row_end) begin
        if (zoom_pos) begin
          if (cur_rep_y <= RepW'(1)) begin
            src_row_d = row_step;
            rep_y_d   = rep;
          end else begin
            rep_y_d = cur_rep_y - RepW'(1);
          end
        end else begin
          src_row_d = row_min[RowW-1:0];
        end
        src_col_d = {8'd0, cfg_i.start_col};
        rep_x_d   = rep;
        col_cnt_d = '0;
        row_cnt_d = cur_row_cnt + CntW'(1);
      end else begin
        if (zoom_pos) begin
          if (cur_rep_x <= RepW'(1)) begin
            src_col_d = cur_src_col + ColW'(1);
            rep_x_d   = rep;
          end else begin
            rep_x_d = cur_rep_x - RepW'(1);
          end
        end else begin
          src_col_d = cur_src_col + {11'd0, mag};
        end
        col_cnt_d = cur_col_cnt + CntW'(1);
      end
    end
  end

  // pixel register valid flag
  always_comb begin
    pix_valid_d = pix_valid_q;
    if (accept) begin
      pix_valid_d = emit;
    end else if (down_ready_i) begin
      pix_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      src_col_q   <= '0;
      src_row_q   <= '0;
      rep_x_q     <= '0;
      rep_y_q     <= '0;
      active_q    <= 1'b0;
      pix_valid_q <= 1'b0;
    end else begin
      pix_valid_q <= pix_valid_d;
      if (accept && emit) begin
        col_cnt_q <= col_cnt_d;
        row_cnt_q <= row_cnt_d;
        src_col_q <= src_col_d;
        src_row_q <= src_row_d;
        rep_x_q   <= rep_x_d;
        rep_y_q   <= rep_y_d;
        active_q  <= active_d;
      end
    end
  end

  // pixel payload, loaded with each transaction that emits
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      pix_q.src_row      <= cur_src_row;
      pix_q.src_col      <= cur_src_col;
      pix_q.width        <= w_eff;
      pix_q.screen_col   <= cur_col_cnt;
      pix_q.screen_row   <= cur_row_cnt;
      pix_q.out_of_range <= cur_oor;
      pix_q.last         <= cur_last;
    end
  end

  assign pix_valid_o = pix_valid_q;
  assign pix_o       = pix_q;

  `ZBAG_ASSERT(a_last_ends_pass, clk_i, rst_ni, accept && emit && cur_last |=> !active_q, "pass still active after last pixel")
  `ZBAG_ASSERT(a_restart_origin, clk_i, rst_ni, accept && restart_i |=> pix_valid_q && pix_q.screen_col == '0 && pix_q.screen_row == '0, "restart did not begin at the origin")
  `ZBAG_ASSERT(a_idle_silent, clk_i, rst_ni, accept && !restart_i && !active_q |=> !pix_valid_q, "idle advance produced a pixel")

endmodule

### hw/rtl/zbag_addr.sv
`include "zoomed_blit_address_generator_macros.svh"

module zbag_addr
  import zbag_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pix_valid_i,
  input  pix_t             pix_i,
  output logic             adv_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [AddrW-1:0] src_addr_o,
  output logic [CntW-1:0]  screen_col_o,
  output logic [CntW-1:0]  screen_row_o,
  output logic             out_of_range_o,
  output logic             last_o
);

  logic             out_valid_q;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [CntW-1:0]  scol_q, srow_q;
  logic             oor_q, last_q;
  logic [AddrW-1:0] row_ext, prod;

  // row times stride plus column, kept modulo the address space
  assign row_ext = {{(AddrW-RowW){pix_i.src_row[RowW-1]}}, pix_i.src_row};
  assign prod    = row_ext * {{(AddrW-DimW){1'b0}}, pix_i.width};
  assign addr_d  = prod + {{(AddrW-ColW){1'b0}}, pix_i.src_col};

  // result register frees when empty or taken
  assign adv_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= pix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && pix_valid_i) begin
      addr_q <= addr_d;
      scol_q <= pix_i.screen_col;
      srow_q <= pix_i.screen_row;
      oor_q  <= pix_i.out_of_range;
      last_q <= pix_i.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign src_addr_o     = addr_q;
  assign screen_col_o   = scol_q;
  assign screen_row_o   = srow_q;
  assign out_of_range_o = oor_q;
  assign last_o         = last_q;

  `ZBAG_ASSERT(a_pixel_lands, clk_i, rst_ni, pix_valid_i && adv_o |=> out_valid_q, "pixel lost between stages")

endmodule

### hw/rtl/zoomed_blit_address_generator.sv
// Zoomed blit address generator: walks a screen rectangle of (span_cols+1) x (span_rows+1)
// pixels in raster order and returns, per pixel, the source address row*width+col, the
// screen position, an out-of-range flag and tlast on the final pixel. Each input
// transaction with tdata bit 0 set starts a new pass and yields its first pixel; with bit 0
// clear it yields the next pixel, or nothing when no pass is running. One transaction is
// taken per clock while the input is ready; each result passes through one pixel register
// (walk counters) and then one result register (address multiply-add), and the input stays
// ready while a result waits as long as the pixel register is empty. Configuration writes
// are always ready, take effect on the next step and belong between passes.
module zoomed_blit_address_generator
  import zbag_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_SPAN   = 2048
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [DimW-1:0]     cfg_data_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [0] restart, [7:1] zero
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,   // [19:0] src_addr, [30:20] screen_col,
                                              // [41:31] screen_row, [42] out_of_range,
                                              // [47:43] zero
  output logic                m_axis_tlast
);

  cfg_t             cfg;
  pix_t             pix;
  logic             pix_valid, adv;
  logic [AddrW-1:0] src_addr;
  logic [CntW-1:0]  screen_col, screen_row;
  logic             out_of_range;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  zbag_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // raster walk and pixel register
  zbag_walk #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_SPAN   (MAX_SPAN)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .restart_i    (s_axis_tdata[0]),
    .down_ready_i (adv),
    .pix_valid_o  (pix_valid),
    .pix_o        (pix)
  );

  // address multiply-add and result register
  zbag_addr u_addr (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pix_valid_i    (pix_valid),
    .pix_i          (pix),
    .adv_o          (adv),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .src_addr_o     (src_addr),
    .screen_col_o   (screen_col),
    .screen_row_o   (screen_row),
    .out_of_range_o (out_of_range),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, out_of_range, screen_row, screen_col, src_addr};

endmodule
